>>> rtl/bmp_pkg.sv
// shared constants and types for the binomial coefficient modulo prime core
package bmp_pkg;

  // field widths
  localparam int COEF_W = 30;
  localparam int ARG_W  = 12;

  // modulus, inverse exponent p-2 and reduction constant floor(2^60 / p)
  localparam logic [29:0] PRIME      = 30'd1000000007;
  localparam logic [29:0] INV_EXP    = 30'd1000000005;
  localparam logic [30:0] BARRETT_MU = 31'd1152921496;

  // pipeline depth of one modular multiplier
  localparam int MUL_LATENCY = 4;

  // table build sequencer
  typedef enum logic [1:0] {
    BUILD_FACT,
    BUILD_POW,
    BUILD_INV,
    BUILD_RUN
  } build_state_t;

endpackage

>>> rtl/bmp_modmul.sv
// pipelined 30-bit modular multiplier with barrett reduction, four stages
module bmp_modmul
  import bmp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              vin,
  input  logic [COEF_W-1:0] a,
  input  logic [COEF_W-1:0] b,
  output logic              vout,
  output logic [COEF_W-1:0] res
);

  logic [MUL_LATENCY-1:0] v;
  logic [59:0] prod1;
  logic [61:0] quot2;
  logic [31:0] low2;
  logic [31:0] qp3;
  logic [31:0] low3;
  logic [31:0] rem4;
  logic [31:0] rem4b;
  logic [31:0] rem4c;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[MUL_LATENCY-2:0], vin};
    end
  end

  // final correction: remainder is below three times the modulus
  always_comb begin
    rem4  = low3 - qp3;
    rem4b = (rem4 >= 32'(PRIME)) ? rem4 - 32'(PRIME) : rem4;
    rem4c = (rem4b >= 32'(PRIME)) ? rem4b - 32'(PRIME) : rem4b;
  end

  // product, quotient estimate, quotient times modulus, correction
  always_ff @(posedge clk) begin
    if (en) begin
      prod1 <= 60'(a) * 60'(b);
      quot2 <= 62'(prod1[59:29]) * 62'(BARRETT_MU);
      low2  <= prod1[31:0];
      qp3   <= 32'(quot2[61:31]) * 32'(PRIME);
      low3  <= low2;
      res   <= rem4c[COEF_W-1:0];
    end
  end

  assign vout = v[MUL_LATENCY-1];

endmodule

>>> rtl/binomial_mod_prime_core.sv
// top level: factorial table build and pipelined binomial coefficient queries
//
// After reset the core builds i! mod p forward and the inverse factorials
// backward from one modular exponentiation of the last factorial; during this
// build s_tready stays low. Each table entry and each step of the
// exponentiation is paced by one four-stage modular multiplier that is waited
// on after each request. Once built, a request is taken every cycle while the
// output is not stalled; it passes one table read stage, two modular
// multipliers in series and the output register. A stall on the output side
// holds the whole pipeline.
module binomial_mod_prime_core
  import bmp_pkg::*;
#(
  parameter int TABLE_ENTRIES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // set_size [11:0], choose_count [23:12]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // coefficient [29:0], zero fill
);

  localparam int AW = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

  // tables, the inverse table kept twice for two reads per cycle
  logic [COEF_W-1:0] fact_mem [TABLE_ENTRIES];
  logic [COEF_W-1:0] inva_mem [TABLE_ENTRIES];
  logic [COEF_W-1:0] invb_mem [TABLE_ENTRIES];

  // build sequencer registers
  build_state_t      state, state_next;
  logic [AW-1:0]     idx, idx_next;
  logic              pend, pend_next;
  logic              phase, phase_next;
  logic [COEF_W-1:0] fact_prev, fact_prev_next;
  logic [COEF_W-1:0] acc, acc_next;
  logic [COEF_W-1:0] sq, sq_next;
  logic [COEF_W-1:0] expo, expo_next;
  logic [COEF_W-1:0] inv_cur, inv_cur_next;

  logic              issue;
  logic [COEF_W-1:0] op_a, op_b;
  logic              fwe, iwe;
  logic [AW-1:0]     fwa, iwa;
  logic [COEF_W-1:0] fwd, iwd;

  logic              building;
  logic              adv;
  logic              accept;

  logic [ARG_W-1:0]  n_in, k_in, diff_in;
  logic              zero_in;

  logic              rd_v;
  logic              zero_rd;
  logic [COEF_W-1:0] fact_rd, inva_rd, invb_rd;
  logic [COEF_W-1:0] fact_d [MUL_LATENCY];
  logic              zero_d [2*MUL_LATENCY];

  logic              mm1_vin, mm1_vout, mm2_vout;
  logic [COEF_W-1:0] mm1_a, mm1_b, mm1_res, mm2_res;
  logic [COEF_W-1:0] coef;

  assign building = (state != BUILD_RUN);
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = !building && adv;
  assign accept   = s_tvalid && s_tready;

  // build sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BUILD_FACT;
      idx       <= '0;
      pend      <= 1'b0;
      phase     <= 1'b0;
      fact_prev <= COEF_W'(1);
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      pend      <= pend_next;
      phase     <= phase_next;
      fact_prev <= fact_prev_next;
    end
  end

  always_ff @(posedge clk) begin
    acc     <= acc_next;
    sq      <= sq_next;
    expo    <= expo_next;
    inv_cur <= inv_cur_next;
  end

  // build sequencer: factorials, one exponentiation, inverses downward
  always_comb begin
    state_next     = state;
    idx_next       = idx;
    pend_next      = pend;
    phase_next     = phase;
    fact_prev_next = fact_prev;
    acc_next       = acc;
    sq_next        = sq;
    expo_next      = expo;
    inv_cur_next   = inv_cur;
    issue          = 1'b0;
    op_a           = fact_prev;
    op_b           = COEF_W'(idx);
    fwe            = 1'b0;
    fwa            = idx;
    fwd            = mm1_res;
    iwe            = 1'b0;
    iwa            = idx - AW'(1);
    iwd            = mm1_res;
    case (state)
      BUILD_FACT: begin
        if (!pend) begin
          issue     = 1'b1;
          op_b      = (idx == '0) ? COEF_W'(1) : COEF_W'(idx);
          pend_next = 1'b1;
        end else if (mm1_vout) begin
          fwe            = 1'b1;
          fact_prev_next = mm1_res;
          pend_next      = 1'b0;
          if (idx == LAST) begin
            state_next = BUILD_POW;
            sq_next    = mm1_res;
            acc_next   = COEF_W'(1);
            expo_next  = INV_EXP;
            phase_next = 1'b0;
          end else begin
            idx_next = idx + AW'(1);
          end
        end
      end
      BUILD_POW: begin
        if (!pend) begin
          if (expo == '0) begin
            state_next   = BUILD_INV;
            iwe          = 1'b1;
            iwa          = idx;
            iwd          = acc;
            inv_cur_next = acc;
          end else if (!phase) begin
            if (expo[0]) begin
              issue     = 1'b1;
              op_a      = acc;
              op_b      = sq;
              pend_next = 1'b1;
            end else begin
              phase_next = 1'b1;
            end
          end else begin
            issue     = 1'b1;
            op_a      = sq;
            op_b      = sq;
            pend_next = 1'b1;
          end
        end else if (mm1_vout) begin
          pend_next = 1'b0;
          if (!phase) begin
            acc_next   = mm1_res;
            phase_next = 1'b1;
          end else begin
            sq_next    = mm1_res;
            expo_next  = expo >> 1;
            phase_next = 1'b0;
          end
        end
      end
      BUILD_INV: begin
        if (!pend) begin
          issue     = 1'b1;
          op_a      = inv_cur;
          op_b      = COEF_W'(idx);
          pend_next = 1'b1;
        end else if (mm1_vout) begin
          iwe          = 1'b1;
          inv_cur_next = mm1_res;
          pend_next    = 1'b0;
          if (idx == AW'(1)) begin
            state_next = BUILD_RUN;
          end else begin
            idx_next = idx - AW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // request decode
  always_comb begin
    n_in    = s_tdata[11:0];
    k_in    = s_tdata[23:12];
    diff_in = n_in - k_in;
    zero_in = (k_in > n_in) || (32'(n_in) >= 32'(TABLE_ENTRIES));
  end

  // table memories: build writes, registered query reads
  always_ff @(posedge clk) begin
    if (fwe) begin
      fact_mem[fwa] <= fwd;
    end
    if (adv) begin
      fact_rd <= fact_mem[AW'(n_in)];
    end
  end

  always_ff @(posedge clk) begin
    if (iwe) begin
      inva_mem[iwa] <= iwd;
    end
    if (adv) begin
      inva_rd <= inva_mem[AW'(k_in)];
    end
  end

  always_ff @(posedge clk) begin
    if (iwe) begin
      invb_mem[iwa] <= iwd;
    end
    if (adv) begin
      invb_rd <= invb_mem[AW'(diff_in)];
    end
  end

  // read stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
    end else if (adv) begin
      rd_v <= accept;
    end
  end

  // side data delayed alongside the multipliers
  always_ff @(posedge clk) begin
    if (adv) begin
      zero_rd   <= zero_in;
      fact_d[0] <= fact_rd;
      for (int i = 1; i < MUL_LATENCY; i++) begin
        fact_d[i] <= fact_d[i-1];
      end
      zero_d[0] <= zero_rd;
      for (int i = 1; i < 2*MUL_LATENCY; i++) begin
        zero_d[i] <= zero_d[i-1];
      end
    end
  end

  // first multiplier is shared with the build sequencer
  always_comb begin
    mm1_vin = building ? issue : rd_v;
    mm1_a   = building ? op_a : inva_rd;
    mm1_b   = building ? op_b : invb_rd;
  end

  bmp_modmul u_mul_denom (
    .clk  (clk),
    .rst  (rst),
    .en   (adv),
    .vin  (mm1_vin),
    .a    (mm1_a),
    .b    (mm1_b),
    .vout (mm1_vout),
    .res  (mm1_res)
  );

  bmp_modmul u_mul_numer (
    .clk  (clk),
    .rst  (rst),
    .en   (adv),
    .vin  (mm1_vout && !building),
    .a    (mm1_res),
    .b    (fact_d[MUL_LATENCY-1]),
    .vout (mm2_vout),
    .res  (mm2_res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= mm2_vout;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      coef <= zero_d[2*MUL_LATENCY-1] ? '0 : mm2_res;
    end
  end

  assign m_tdata = {2'b00, coef};

endmodule

>>> rtl/bmp_checker.sv
// port-level checker for the binomial coefficient core, with its bind
module bmp_checker
  import bmp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [23:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // no result and no request taken right after reset, tables still building
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid && !s_tready)
    else $error("activity right after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // every result is a reduced residue
  a_residue: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[31:30] == 2'b00 && m_tdata[29:0] < PRIME)
    else $error("result not reduced");

  // a stalled output holds the pipeline and takes no request
  a_stall_block: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("request taken while output stalled");

endmodule

bind binomial_mod_prime_core bmp_checker u_bmp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> sim/binomial_mod_prime_checker.sv
// checker for the binomial coefficient core: predicts and compares results
`timescale 1ns / 100ps

module binomial_mod_prime_checker
  import bmp_pkg::*;
#(
  parameter int TABLE_ENTRIES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // set_size [11:0], choose_count [23:12]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // coefficient [29:0], zero fill
  output int          fail_count,
  output int          outstanding,
  output int          checked_count
);

  localparam longint unsigned MODULUS = 64'd1000000007;

  logic [COEF_W-1:0] fact_mem [TABLE_ENTRIES];
  logic [COEF_W-1:0] inv_fact_mem [TABLE_ENTRIES];
  logic [COEF_W-1:0] coef_queue [$];

  function automatic longint unsigned mod_mul(longint unsigned a, longint unsigned b);
    return (a * b) % MODULUS;
  endfunction

  function automatic longint unsigned mod_pow(longint unsigned base, longint unsigned ex);
    longint unsigned acc;
    longint unsigned sq;
    acc = 1;
    sq  = base % MODULUS;
    while (ex != 0) begin
      if (ex[0]) acc = mod_mul(acc, sq);
      sq = mod_mul(sq, sq);
      ex = ex >> 1;
    end
    return acc;
  endfunction

  // C(n,k) mod p from the local tables
  function automatic logic [COEF_W-1:0] binom_mod(int unsigned n, int unsigned k);
    longint unsigned r;
    if (k > n || n >= TABLE_ENTRIES) return '0;
    r = mod_mul(fact_mem[n], inv_fact_mem[k]);
    r = mod_mul(r, inv_fact_mem[n-k]);
    return r[COEF_W-1:0];
  endfunction

  // factorial and inverse factorial tables
  initial begin
    longint unsigned f;
    f = 1;
    fact_mem[0]     = COEF_W'(1);
    inv_fact_mem[0] = COEF_W'(1);
    for (int i = 1; i < TABLE_ENTRIES; i++) begin
      f = mod_mul(f, i);
      fact_mem[i]     = f[COEF_W-1:0];
      inv_fact_mem[i] = COEF_W'(mod_pow(f, 64'd1000000005));
    end
  end

  // watch both channels
  always @(posedge clk) begin
    logic [COEF_W-1:0] want;
    if (rst) begin
      fail_count    <= 0;
      outstanding   <= 0;
      checked_count <= 0;
    end else begin
      if (s_tvalid && s_tready)
        coef_queue.push_back(binom_mod(32'(s_tdata[11:0]), 32'(s_tdata[23:12])));
      if (m_tvalid && m_tready) begin
        checked_count <= checked_count + 1;
        if (coef_queue.size() == 0) begin
          $error("unexpected result: coefficient actual %0d", m_tdata[29:0]);
          fail_count <= fail_count + 1;
        end else begin
          want = coef_queue.pop_front();
          if (m_tdata[29:0] !== want) begin
            $error("coefficient mismatch: expected %0d actual %0d", want, m_tdata[29:0]);
            fail_count <= fail_count + 1;
          end
        end
      end
      outstanding <= coef_queue.size();
    end
  end

endmodule

>>> sim/binomial_mod_prime_core_tb.sv
// testbench top for the binomial coefficient core: stimulus and verdict
`timescale 1ns / 100ps

module binomial_mod_prime_core_tb;
  import bmp_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // set_size [11:0], choose_count [23:12]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // coefficient [29:0], zero fill

  int fail_count;
  int outstanding;
  int checked_count;
  int sent_count = 0;
  int cycle_count = 0;
  bit hold_off_go = 1'b0;

  always #6 clk = ~clk;

  binomial_mod_prime_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  binomial_mod_prime_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .outstanding(outstanding), .checked_count(checked_count)
  );

  // timeout guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // offer one request and hold it until taken; valid stays high into the next one unless a gap is given
  task automatic send_request(logic [11:0] n, logic [11:0] k, int gap);
    s_tdata  <= {k, n};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sent_count++;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // receiver: random readiness during the directed part, one long hold-off, then changing stall patterns
  initial begin
    int mode;
    int hold;
    @(negedge clk);
    while (!hold_off_go) begin
      m_tready <= ($urandom_range(0, 3) != 0);
      @(negedge clk);
    end
    m_tready <= 1'b0;
    for (hold = 0; hold < 300; hold++) @(negedge clk);
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(20, 80)) begin
        case (mode)
          0: begin
            m_tready <= 1'b1;
          end
          1: begin
            m_tready <= 1'($urandom_range(0, 1));
          end
          default: begin
            m_tready <= ($urandom_range(0, 4) == 0);
          end
        endcase
        @(negedge clk);
      end
    end
  end

  // stimulus and verdict
  initial begin
    logic [11:0] n;
    logic [11:0] k;
    int burst;
    int drained;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // edges: zero, full table, k above n, k equal n, symmetry
    send_request(12'd0,    12'd0,    0);
    send_request(12'd4095, 12'd4095, 0);
    send_request(12'd4095, 12'd0,    1);
    send_request(12'd4095, 12'd2048, 0);
    send_request(12'd4095, 12'd1,    0);
    send_request(12'd4095, 12'd4094, 2);
    send_request(12'd0,    12'd4095, 0);
    send_request(12'd1,    12'd2,    0);
    send_request(12'd4094, 12'd4095, 0);
    send_request(12'd1,    12'd0,    0);
    send_request(12'd1,    12'd1,    3);
    send_request(12'd5,    12'd3,    0);
    send_request(12'd10,   12'd5,    0);
    send_request(12'd2048, 12'd1024, 0);
    send_request(12'd100,  12'd99,   0);
    send_request(12'd2730, 12'd1365, 0);
    send_request(12'd1365, 12'd2730, 0);
    send_request(12'd4095, 12'd4095, 1);

    // random part: mostly valid k <= n, some k above n
    hold_off_go = 1'b1;
    for (int i = 0; i < RANDOM_ITEMS; i += burst) begin
      burst = $urandom_range(1, 24);
      for (int j = 0; j < burst; j++) begin
        n = 12'($urandom);
        k = ($urandom_range(0, 3) != 0) ? 12'($urandom_range(0, n)) : 12'($urandom);
        send_request(n, k, (j == burst - 1) ? $urandom_range(1, 12) : 0);
      end
    end
    s_tvalid <= 1'b0;

    // drain, then let the pipeline settle
    drained = 0;
    while (outstanding != 0 && drained < 20000) begin
      @(posedge clk);
      drained++;
    end
    repeat (30) @(posedge clk);

    $display("sent %0d queries, %0d coefficients compared, incl. a 300-cycle output stall",
             sent_count, checked_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
